// File: src/sdv_pkg.sv
package sdv_pkg;

  // coordinate format and extra fraction bits taken for the length
  localparam int COORD_WIDTH = 32;
  localparam int GUARD_BITS  = 14;

  // derived datapath widths
  localparam int ABS_WIDTH    = COORD_WIDTH + 1;
  localparam int SQ_WIDTH     = 2 * ABS_WIDTH;
  localparam int SUM_WIDTH    = SQ_WIDTH + 2;
  localparam int RAD_WIDTH    = SUM_WIDTH + 2 * GUARD_BITS;
  localparam int LEN_WIDTH    = RAD_WIDTH / 2;
  localparam int SQ_REM_WIDTH = LEN_WIDTH + 2;
  localparam int PROD_WIDTH   = ABS_WIDTH + COORD_WIDTH;
  localparam int NUM_WIDTH    = PROD_WIDTH + GUARD_BITS;
  localparam int QUO_WIDTH    = COORD_WIDTH + 2;

  // input register, square/product, sum, root stages, divider stages
  localparam int PIPE_DEPTH   = 3 + LEN_WIDTH + QUO_WIDTH;

  // per-axis dividend travelling alongside the length computation
  typedef struct packed {
    logic [PROD_WIDTH-1:0] prod;
    logic                  neg;
  } num_t;

endpackage

// File: src/sdv_lane.sv
module sdv_lane
  import sdv_pkg::*;
(
  input  logic                   clk,
  input  logic                   adv,
  input  logic [COORD_WIDTH-1:0] src,
  input  logic [COORD_WIDTH-1:0] dst,
  input  logic [COORD_WIDTH-1:0] mag,
  output logic [SQ_WIDTH-1:0]    sq,
  output num_t                   num
);

  logic [ABS_WIDTH-1:0]   diff;
  logic [ABS_WIDTH-1:0]   abs_d;
  logic [COORD_WIDTH-1:0] abs_m;
  logic [ABS_WIDTH-1:0]   abs_d_r;
  logic [COORD_WIDTH-1:0] abs_m_r;
  logic                   neg_r;
  logic [SQ_WIDTH-1:0]    sq_r;
  num_t                   prod_r;
  num_t                   dly_r [LEN_WIDTH+1];

  // exact difference and magnitudes
  assign diff  = {dst[COORD_WIDTH-1], dst} - {src[COORD_WIDTH-1], src};
  assign abs_d = diff[ABS_WIDTH-1] ? (~diff + 1'b1) : diff;
  assign abs_m = mag[COORD_WIDTH-1] ? (~mag + 1'b1) : mag;

  // difference, then square and scaled product, then delay to meet the length
  always_ff @(posedge clk) begin
    if (adv) begin
      abs_d_r     <= abs_d;
      abs_m_r     <= abs_m;
      neg_r       <= diff[ABS_WIDTH-1] ^ mag[COORD_WIDTH-1];
      sq_r        <= abs_d_r * abs_d_r;
      prod_r.prod <= abs_d_r * abs_m_r;
      prod_r.neg  <= neg_r;
      dly_r[0]    <= prod_r;
      for (int i = 1; i <= LEN_WIDTH; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign sq  = sq_r;
  assign num = dly_r[LEN_WIDTH];

endmodule

// File: src/sdv_isqrt.sv
module sdv_isqrt
  import sdv_pkg::*;
(
  input  logic                 clk,
  input  logic                 adv,
  input  logic [RAD_WIDTH-1:0] rad,
  output logic [LEN_WIDTH-1:0] len
);

  logic [SQ_REM_WIDTH-1:0] rem_r  [LEN_WIDTH];
  logic [LEN_WIDTH-1:0]    root_r [LEN_WIDTH];
  logic [RAD_WIDTH-1:0]    rad_r  [LEN_WIDTH];
  logic [SQ_REM_WIDTH-1:0] rem_s  [LEN_WIDTH+1];
  logic [LEN_WIDTH-1:0]    root_s [LEN_WIDTH+1];
  logic [RAD_WIDTH-1:0]    rad_s  [LEN_WIDTH+1];

  // stage inputs
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad;

  // one root bit per stage, two radicand bits consumed each time
  for (genvar k = 0; k < LEN_WIDTH; k++) begin : g_stage
    logic [SQ_REM_WIDTH+1:0] acc;
    logic [SQ_REM_WIDTH+1:0] trial;

    assign acc   = {rem_s[k], rad_s[k][RAD_WIDTH-1 -: 2]};
    assign trial = (SQ_REM_WIDTH+2)'({root_s[k], 2'b01});

    always_ff @(posedge clk) begin
      if (adv) begin
        if (acc >= trial) begin
          rem_r[k]  <= SQ_REM_WIDTH'(acc - trial);
          root_r[k] <= {root_s[k][LEN_WIDTH-2:0], 1'b1};
        end else begin
          rem_r[k]  <= SQ_REM_WIDTH'(acc);
          root_r[k] <= {root_s[k][LEN_WIDTH-2:0], 1'b0};
        end
        rad_r[k] <= rad_s[k] << 2;
      end
    end

    assign rem_s[k+1]  = rem_r[k];
    assign root_s[k+1] = root_r[k];
    assign rad_s[k+1]  = rad_r[k];
  end

  assign len = root_s[LEN_WIDTH];

endmodule

// File: src/sdv_div.sv
module sdv_div
  import sdv_pkg::*;
(
  input  logic                 clk,
  input  logic                 adv,
  input  num_t                 num,
  input  logic [LEN_WIDTH-1:0] len,
  output logic [QUO_WIDTH-1:0] quo,
  output logic                 neg
);

  logic [NUM_WIDTH-1:0] numw;
  logic [LEN_WIDTH-1:0] rem_r [QUO_WIDTH];
  logic [QUO_WIDTH-1:0] lo_r  [QUO_WIDTH];
  logic [QUO_WIDTH-1:0] quo_r [QUO_WIDTH];
  logic [LEN_WIDTH-1:0] len_r [QUO_WIDTH];
  logic                 neg_r [QUO_WIDTH];
  logic [LEN_WIDTH-1:0] rem_s [QUO_WIDTH+1];
  logic [QUO_WIDTH-1:0] lo_s  [QUO_WIDTH+1];
  logic [QUO_WIDTH-1:0] quo_s [QUO_WIDTH+1];
  logic [LEN_WIDTH-1:0] len_s [QUO_WIDTH+1];
  logic                 neg_s [QUO_WIDTH+1];

  // dividend carries the guard bits; its upper part is already below the divisor
  assign numw     = {num.prod, {GUARD_BITS{1'b0}}};
  assign rem_s[0] = LEN_WIDTH'(numw[NUM_WIDTH-1:QUO_WIDTH]);
  assign lo_s[0]  = numw[QUO_WIDTH-1:0];
  assign quo_s[0] = '0;
  assign len_s[0] = len;
  assign neg_s[0] = num.neg;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_stage
    logic [LEN_WIDTH:0] acc;
    logic               take;

    assign acc  = {rem_s[k], lo_s[k][QUO_WIDTH-1]};
    assign take = (acc >= {1'b0, len_s[k]});

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= take ? LEN_WIDTH'(acc - {1'b0, len_s[k]}) : LEN_WIDTH'(acc);
        quo_r[k] <= {quo_s[k][QUO_WIDTH-2:0], take};
        lo_r[k]  <= lo_s[k] << 1;
        len_r[k] <= len_s[k];
        neg_r[k] <= neg_s[k];
      end
    end

    assign rem_s[k+1] = rem_r[k];
    assign lo_s[k+1]  = lo_r[k];
    assign quo_s[k+1] = quo_r[k];
    assign len_s[k+1] = len_r[k];
    assign neg_s[k+1] = neg_r[k];
  end

  assign quo = quo_s[QUO_WIDTH];
  assign neg = neg_s[QUO_WIDTH];

endmodule

// File: src/scaled_direction_vector_unit.sv
// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    source, dest and magnitude
// out_     output     out_valid / out_ready  vec_x/y/z and zero_length
//
// one transaction per cycle while the pipeline is not stalled
// the depth comes mostly from the 48-stage square root and the 34-stage divider of each lane
// reset (rst_n, synchronous) clears the valid bits only; data registers are not reset
// the pipeline stalls as a whole only when a result waits at the output and the
// last stage holds a further one; while it stalls, no stage moves, bubbles included
module scaled_direction_vector_unit
  import sdv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] in_source_x,
  input  logic [COORD_WIDTH-1:0] in_source_y,
  input  logic [COORD_WIDTH-1:0] in_source_z,
  input  logic [COORD_WIDTH-1:0] in_dest_x,
  input  logic [COORD_WIDTH-1:0] in_dest_y,
  input  logic [COORD_WIDTH-1:0] in_dest_z,
  input  logic [COORD_WIDTH-1:0] in_magnitude,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] out_vec_x,
  output logic [COORD_WIDTH-1:0] out_vec_y,
  output logic [COORD_WIDTH-1:0] out_vec_z,
  output logic                   out_zero_length
);

  localparam logic [QUO_WIDTH-1:0]   SAT_Q = QUO_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});

  logic                   adv;
  logic [COORD_WIDTH-1:0] src [3];
  logic [COORD_WIDTH-1:0] dst [3];
  logic [SQ_WIDTH-1:0]    sq  [3];
  num_t                   num [3];
  logic [QUO_WIDTH-1:0]   quo [3];
  logic                   qneg [3];
  logic [COORD_WIDTH-1:0] res [3];
  logic [SUM_WIDTH-1:0]   sum_r;
  logic [LEN_WIDTH-1:0]   len;
  logic                   zdly_r [LEN_WIDTH+QUO_WIDTH];
  logic                   vld_r  [PIPE_DEPTH];
  logic [COORD_WIDTH-1:0] vec_r  [3];
  logic                   zero_r;
  logic                   out_valid_r;

  // pipeline advances unless a waiting result would be overwritten
  assign adv      = !(out_valid_r && !out_ready && vld_r[PIPE_DEPTH-1]);
  // no transaction is taken while in reset
  assign in_ready = adv && rst_n;

  assign src[0] = in_source_x;
  assign src[1] = in_source_y;
  assign src[2] = in_source_z;
  assign dst[0] = in_dest_x;
  assign dst[1] = in_dest_y;
  assign dst[2] = in_dest_z;

  // per-axis difference, square and dividend
  for (genvar g = 0; g < 3; g++) begin : g_lane
    sdv_lane u_lane (
      .clk (clk),
      .adv (adv),
      .src (src[g]),
      .dst (dst[g]),
      .mag (in_magnitude),
      .sq  (sq[g]),
      .num (num[g])
    );
  end

  // merge the squares into the sum
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= SUM_WIDTH'(sq[0]) + SUM_WIDTH'(sq[1]) + SUM_WIDTH'(sq[2]);
      zdly_r[0] <= (sum_r == '0);
      for (int i = 1; i < LEN_WIDTH + QUO_WIDTH; i++) begin
        zdly_r[i] <= zdly_r[i-1];
      end
    end
  end

  // length with guard bits
  sdv_isqrt u_isqrt (
    .clk (clk),
    .adv (adv),
    .rad ({sum_r, {(2*GUARD_BITS){1'b0}}}),
    .len (len)
  );

  // per-axis division and sign/saturation
  for (genvar g = 0; g < 3; g++) begin : g_div
    sdv_div u_div (
      .clk (clk),
      .adv (adv),
      .num (num[g]),
      .len (len),
      .quo (quo[g]),
      .neg (qneg[g])
    );

    always_comb begin
      if (zdly_r[LEN_WIDTH+QUO_WIDTH-1] || quo[g] == '0) begin
        res[g] = '0;
      end else if (qneg[g]) begin
        res[g] = ~quo[g][COORD_WIDTH-1:0] + 1'b1;
      end else if (quo[g] > SAT_Q) begin
        res[g] = SAT_Q[COORD_WIDTH-1:0];
      end else begin
        res[g] = quo[g][COORD_WIDTH-1:0];
      end
    end
  end

  // valid tracking and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        vld_r[0] <= in_valid;
        for (int i = 1; i < PIPE_DEPTH; i++) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (adv && vld_r[PIPE_DEPTH-1]) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv && vld_r[PIPE_DEPTH-1]) begin
      vec_r[0] <= res[0];
      vec_r[1] <= res[1];
      vec_r[2] <= res[2];
      zero_r   <= zdly_r[LEN_WIDTH+QUO_WIDTH-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vec_x       = vec_r[0];
  assign out_vec_y       = vec_r[1];
  assign out_vec_z       = vec_r[2];
  assign out_zero_length = zero_r;

endmodule
